### hw/rtl/sh24_pkg.sv
// Package for the SipHash-2-4 keyed hash block.
// Holds the lane type, the sequencer states, register indexes and init constants.
// No dependencies.
`default_nettype none

package sh24_pkg;

   localparam logic [63:0] INIT_C0 = 64'h736f6d6570736575;
   localparam logic [63:0] INIT_C1 = 64'h646f72616e646f6d;
   localparam logic [63:0] INIT_C2 = 64'h6c7967656e657261;
   localparam logic [63:0] INIT_C3 = 64'h7465646279746573;

   localparam logic [63:0] FINAL_XOR = 64'h00000000000000ff;

   localparam logic CSR_KEY_LOW  = 1'b0;
   localparam logic CSR_KEY_HIGH = 1'b1;

   typedef struct packed {
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
   } sip_lanes_type;

   typedef enum logic [1:0] {
      SH_IDLE,
      SH_COMPRESS,
      SH_FINAL
   } sh_state_type;

endpackage

`default_nettype wire

### hw/rtl/sh24_round.sv
// One SipRound over the four 64-bit lanes, purely combinational.
// Depends on sh24_pkg for the lane type.
`default_nettype none

module sh24_round
   import sh24_pkg::*;
(
   input  wire sip_lanes_type lanes_i,
   output sip_lanes_type      lanes_o
);

   logic [63:0] a0, a1, a2, a3;
   logic [63:0] b0, b1, b2, b3;

   always_comb begin
      a0 = lanes_i.v0 + lanes_i.v1;
      a1 = {lanes_i.v1[50:0], lanes_i.v1[63:51]} ^ a0;
      a0 = {a0[31:0], a0[63:32]};
      a2 = lanes_i.v2 + lanes_i.v3;
      a3 = {lanes_i.v3[47:0], lanes_i.v3[63:48]} ^ a2;
      b0 = a0 + a3;
      b3 = {a3[42:0], a3[63:43]} ^ b0;
      b2 = a2 + a1;
      b1 = {a1[46:0], a1[63:47]} ^ b2;
      lanes_o.v0 = b0;
      lanes_o.v1 = b1;
      lanes_o.v2 = {b2[31:0], b2[63:32]};
      lanes_o.v3 = b3;
   end

endmodule

`default_nettype wire

### hw/rtl/siphash_2_4_keyed_hash.sv
// Top level of the SipHash-2-4 keyed hash block: sequencer, lanes and handshakes.
// Depends on sh24_pkg and the shared round unit sh24_round.
//
// The message streams in as 64-bit little-endian words, one request per word, and the
// 128-bit key is written beforehand through the csr port. All rounds go through one
// shared SipRound unit at one round per cycle. An ordinary word is accepted and then gets
// two rounds. A last word with fewer than eight valid bytes is accepted and gets two tail
// rounds and four final rounds; a full last word also gets two compression rounds first,
// since it is compressed before the empty tail. The hash sits in an output register, and
// the block is ready for the next message while it waits to be taken; the last final
// round holds only if a previous hash is still pending.
`default_nettype none

module siphash_2_4_keyed_hash
   import sh24_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Bits from low: data_word[63:0], byte_count[67:64], zero fill[71:68].
   input  wire logic [71:0] req_tdata,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Bits from low: hash[63:0].
   output logic [63:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_wdata
);

   sh_state_type  state_ff, state_in;
   sip_lanes_type v_ff, v_in, rnd, init;
   logic [1:0]    cnt_ff, cnt_in;
   logic [63:0]   m_ff, m_in;
   logic [7:0]    len_ff, len_in;
   logic          fresh_ff, fresh_in;
   logic          tail_pend_ff, tail_pend_in;
   logic          fin_ff, fin_in;
   logic [63:0]   key_low_ff, key_high_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;

   logic [63:0]   word;
   logic [3:0]    count;
   logic          full_word;
   logic [7:0]    base_len;
   logic [7:0]    part_len;
   logic [63:0]   mask;
   logic [63:0]   tail;
   logic          out_free;

   sh24_round u_round (
      .lanes_i (v_ff),
      .lanes_o (rnd)
   );

   assign word       = req_tdata[63:0];
   assign count      = req_tdata[67:64];
   assign full_word  = !req_tlast || (count >= 4'd8);
   assign base_len   = fresh_ff ? 8'd0 : len_ff;
   assign part_len   = base_len + {4'd0, count};
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == SH_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mask[i*8 +: 8] = (i < int'(count)) ? 8'hff : 8'h00;
      end
      tail = (word & mask) | {part_len, 56'd0};
   end

   always_comb begin
      if (fresh_ff) begin
         init.v0 = key_low_ff ^ INIT_C0;
         init.v1 = key_high_ff ^ INIT_C1;
         init.v2 = key_low_ff ^ INIT_C2;
         init.v3 = key_high_ff ^ INIT_C3;
      end else begin
         init = v_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      v_in         = v_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      len_in       = len_ff;
      fresh_in     = fresh_ff;
      tail_pend_in = tail_pend_ff;
      fin_in       = fin_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         SH_IDLE: begin
            if (req_tvalid) begin
               v_in         = init;
               m_in         = full_word ? word : tail;
               v_in.v3      = init.v3 ^ m_in;
               len_in       = full_word ? (base_len + 8'd8) : part_len;
               tail_pend_in = req_tlast && full_word;
               fin_in       = req_tlast;
               fresh_in     = req_tlast;
               cnt_in       = 2'd0;
               state_in     = SH_COMPRESS;
            end
         end
         SH_COMPRESS: begin
            v_in = rnd;
            if (cnt_ff == 2'd1) begin
               v_in.v0 = rnd.v0 ^ m_ff;
               cnt_in  = 2'd0;
               if (tail_pend_ff) begin
                  m_in         = {len_ff, 56'd0};
                  v_in.v3      = rnd.v3 ^ m_in;
                  tail_pend_in = 1'b0;
               end else if (fin_ff) begin
                  v_in.v2  = rnd.v2 ^ FINAL_XOR;
                  state_in = SH_FINAL;
               end else begin
                  state_in = SH_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         SH_FINAL: begin
            if (cnt_ff != 2'd3) begin
               v_in   = rnd;
               cnt_in = cnt_ff + 2'd1;
            end else if (out_free) begin
               v_in         = rnd;
               rsp_data_in  = rnd.v0 ^ rnd.v1 ^ rnd.v2 ^ rnd.v3;
               rsp_valid_in = 1'b1;
               cnt_in       = 2'd0;
               state_in     = SH_IDLE;
            end
         end
         default: begin
            state_in = SH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SH_IDLE;
         cnt_ff       <= 2'd0;
         fresh_ff     <= 1'b1;
         tail_pend_ff <= 1'b0;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         tail_pend_ff <= tail_pend_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      m_ff        <= m_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= 64'd0;
         key_high_ff <= 64'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_LOW: begin
               key_low_ff <= csr_wdata;
            end
            CSR_KEY_HIGH: begin
               key_high_ff <= csr_wdata;
            end
            default: begin
               key_low_ff <= key_low_ff;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
